### sv/timer_request_queue_macros.svh
// Assertion macros for the timer request queue
`ifndef TIMER_REQUEST_QUEUE_MACROS_SVH
`define TIMER_REQUEST_QUEUE_MACROS_SVH
// concurrent implication check, reset-qualified
`define TRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication check, reset-qualified
`define TRQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### sv/trq_pkg.sv
// Package: constants, types and the delay conversion for the timer request queue
package trq_pkg;
  localparam int unsigned Slots = 32;
  localparam int unsigned IdxW = $clog2(Slots);
  localparam int unsigned CntW = $clog2(Slots + 1);
  localparam int unsigned MaxResults = 32;
  localparam int unsigned ResW = $clog2(MaxResults + 1);

  // ceil(2^38/625): ((usec >> 4) * UsecRecip) >> 38 == usec / 10000 for any 32-bit usec
  localparam logic [28:0] UsecRecip = 29'd439804652;

  localparam logic [1:0] ReqAdd   = 2'd0;
  localparam logic [1:0] ReqAbort = 2'd1;
  localparam logic [1:0] ReqTick  = 2'd2;

  localparam logic [2:0] KindQueued  = 3'd0;
  localparam logic [2:0] KindFull    = 3'd1;
  localparam logic [2:0] KindAborted = 3'd2;
  localparam logic [2:0] KindNotFnd  = 3'd3;
  localparam logic [2:0] KindNullId  = 3'd4;
  localparam logic [2:0] KindExpired = 3'd5;
  localparam logic [2:0] KindNoExp   = 3'd6;

  typedef enum logic [2:0] {
    StIdle, StConv, StAppend, StScan, StWait, StOut
  } state_e;

  // memory port bundle
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [31:0]     wid;
    logic [31:0]     wtgt;
    logic [IdxW-1:0] raddr;
  } mem_req_t;
endpackage

### sv/trq_ram.sv
// Entry store: id and target per slot, one write and one registered read port
module trq_ram (
  input  logic               clk_i,
  input  trq_pkg::mem_req_t  req_i,
  output logic [31:0]        rid_o,
  output logic [31:0]        rtgt_o
);
  logic [63:0] mem_q [trq_pkg::Slots];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= {req_i.wid, req_i.wtgt};
    end
    {rid_o, rtgt_o} <= mem_q[req_i.raddr];
  end
endmodule

### sv/trq_ctrl.sv
// Sequencer: decodes requests, scans and compacts the entry store, emits results
module trq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [31:0]       request_id_i,
  input  logic [31:0]       seconds_i,
  input  logic [31:0]       microseconds_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        result_kind_o,
  output logic [31:0]       done_id_o,
  output logic              last_o,
  output trq_pkg::mem_req_t mem_o,
  input  logic [31:0]       rid_i,
  input  logic [31:0]       rtgt_i
);
  trq_pkg::state_e state_q, state_d;
  logic [31:0] tick_q, tick_d;
  logic [trq_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [1:0]  typ_q, typ_d;
  logic [31:0] id_q, id_d;
  logic [31:0] secs_q, secs_d;
  logic [31:0] usec_q, usec_d;
  logic [31:0] ticks_q, ticks_d;
  logic [trq_pkg::CntW-1:0] rd_q, rd_d;   // scan read position
  logic [trq_pkg::CntW-1:0] wr_q, wr_d;   // compaction write position
  logic [trq_pkg::ResW-1:0] nres_q, nres_d;
  logic        hit_q, hit_d;
  logic        ov_q, ov_d;
  logic [2:0]  kind_q, kind_d;
  logic [31:0] oid_q, oid_d;
  logic        olast_q, olast_d;
  logic [31:0] prod;
  logic [56:0] quo_prod;
  logic [31:0] usec_div;
  logic [31:0] diff;
  logic        reached;

  // seconds*100 via shifts: 64+32+4
  assign prod = (secs_q << 6) + (secs_q << 5) + (secs_q << 2);
  // microseconds/10000 as (microseconds/16)/625 by reciprocal multiply
  assign quo_prod = {29'd0, usec_q[31:4]} * {28'd0, trq_pkg::UsecRecip};
  assign usec_div = {13'd0, quo_prod[56:38]};
  assign diff = tick_q - rtgt_i;
  assign reached = ~diff[31];

  assign in_ready_o    = (state_q == trq_pkg::StIdle) && !ov_q;
  assign out_valid_o   = ov_q;
  assign result_kind_o = kind_q;
  assign done_id_o     = oid_q;
  assign last_o        = olast_q;

  always_comb begin
    state_d = state_q; tick_d = tick_q; cnt_d = cnt_q; typ_d = typ_q;
    id_d = id_q; secs_d = secs_q; usec_d = usec_q; ticks_d = ticks_q;
    rd_d = rd_q; wr_d = wr_q; nres_d = nres_q; hit_d = hit_q;
    ov_d = ov_q; kind_d = kind_q; oid_d = oid_q; olast_d = olast_q;
    mem_o = '0;
    mem_o.raddr = rd_q[trq_pkg::IdxW-1:0];
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      trq_pkg::StIdle: begin
        if (in_valid_i && in_ready_o) begin
          typ_d = req_type_i; id_d = request_id_i;
          secs_d = seconds_i; usec_d = microseconds_i;
          rd_d = '0; wr_d = '0; nres_d = '0; hit_d = 1'b0; ticks_d = '0;
          if (req_type_i == trq_pkg::ReqAdd || req_type_i == trq_pkg::ReqAbort) begin
            if (request_id_i == '0) begin
              ov_d = 1'b1; kind_d = trq_pkg::KindNullId; oid_d = '0; olast_d = 1'b1;
            end else if (req_type_i == trq_pkg::ReqAdd) begin
              if (cnt_q == trq_pkg::CntW'(trq_pkg::Slots)) begin
                ov_d = 1'b1; kind_d = trq_pkg::KindFull;
                oid_d = request_id_i; olast_d = 1'b1;
              end else begin
                state_d = trq_pkg::StConv;
              end
            end else begin
              state_d = trq_pkg::StScan;
            end
          end else if (req_type_i == trq_pkg::ReqTick) begin
            tick_d = tick_q + 32'd1;
            state_d = trq_pkg::StScan;
          end
        end
      end
      trq_pkg::StConv: begin
        // delay in ticks, wrapping at 32 bits
        ticks_d = prod + usec_div;
        state_d = trq_pkg::StAppend;
      end
      trq_pkg::StAppend: begin
        // zero delay rounds up to one tick
        mem_o.we = 1'b1;
        mem_o.waddr = cnt_q[trq_pkg::IdxW-1:0];
        mem_o.wid = id_q;
        mem_o.wtgt = tick_q + ((ticks_q == '0) ? 32'd1 : ticks_q);
        cnt_d = cnt_q + 1'b1;
        ov_d = 1'b1; kind_d = trq_pkg::KindQueued; oid_d = id_q; olast_d = 1'b1;
        state_d = trq_pkg::StIdle;
      end
      trq_pkg::StScan: begin
        // issue read of rd_q, then process returned entry in StWait
        if (rd_q < cnt_q) begin
          state_d = trq_pkg::StWait;
        end else begin
          cnt_d = wr_q;
          state_d = trq_pkg::StIdle;
          if (typ_q == trq_pkg::ReqAbort) begin
            ov_d = 1'b1; kind_d = hit_q ? trq_pkg::KindAborted : trq_pkg::KindNotFnd;
            oid_d = id_q; olast_d = 1'b1;
          end else begin
            if (nres_q == '0) begin
              ov_d = 1'b1; kind_d = trq_pkg::KindNoExp; oid_d = '0; olast_d = 1'b1;
            end else begin
              // last expiry result was held back until scan end
              ov_d = 1'b1; kind_d = trq_pkg::KindExpired; oid_d = oid_q; olast_d = 1'b1;
            end
          end
        end
      end
      trq_pkg::StWait: begin
        rd_d = rd_q + 1'b1;
        if (typ_q == trq_pkg::ReqAbort) begin
          if (!hit_q && rid_i == id_q) begin
            hit_d = 1'b1;
          end else begin
            mem_o.we = 1'b1; mem_o.waddr = wr_q[trq_pkg::IdxW-1:0];
            mem_o.wid = rid_i; mem_o.wtgt = rtgt_i;
            wr_d = wr_q + 1'b1;
          end
          state_d = trq_pkg::StScan;
        end else if (reached && nres_q < trq_pkg::ResW'(trq_pkg::MaxResults)) begin
          // emit previously held expiry, hold this one
          nres_d = nres_q + 1'b1;
          oid_d = rid_i;
          if (nres_q != '0) begin
            ov_d = 1'b1; kind_d = trq_pkg::KindExpired; oid_d = oid_q; olast_d = 1'b0;
            state_d = trq_pkg::StOut;
          end else begin
            state_d = trq_pkg::StScan;
          end
          ticks_d = rid_i;
        end else begin
          mem_o.we = 1'b1; mem_o.waddr = wr_q[trq_pkg::IdxW-1:0];
          mem_o.wid = rid_i; mem_o.wtgt = rtgt_i;
          wr_d = wr_q + 1'b1;
          state_d = trq_pkg::StScan;
        end
      end
      trq_pkg::StOut: begin
        // wait for the emitted result, then hold the new pending id
        if (!ov_q || out_ready_i) begin
          oid_d = ticks_q;
          state_d = trq_pkg::StScan;
        end
      end
      default: state_d = trq_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trq_pkg::StIdle;
      tick_q <= '0; cnt_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tick_q <= tick_d; cnt_q <= cnt_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    typ_q <= typ_d; id_q <= id_d; secs_q <= secs_d; usec_q <= usec_d;
    ticks_q <= ticks_d; rd_q <= rd_d; wr_q <= wr_d; nres_q <= nres_d;
    hit_q <= hit_d; kind_q <= kind_d; oid_q <= oid_d; olast_q <= olast_d;
  end
endmodule

### sv/timer_request_queue.sv
// Top level of the timer request queue
//  channel | handshake             | payload
//  in      | in_valid_i/in_ready_o | req_type_i request_id_i seconds_i microseconds_i
//  out     | out_valid_o/out_ready_i | result_kind_o done_id_o last_o
// An add that is queued passes StConv, which converts microseconds/10000 by
// reciprocal multiply, then StAppend, which appends to memory and sets the result.
// Null id or full list: result shows the cycle after the transfer.
// Abort and tick walk the entry memory: StScan reads each stored entry, then StWait
// handles it (compacting write-back of kept entries); each expiry after the first
// also passes StOut while its result waits for transfer.
// Reset clears tick counter, entry count and handshakes; entries need no clear.
// One request is in work at a time; input waits until its last result transfers.
module timer_request_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] request_id_i,
  input  logic [31:0] seconds_i,
  input  logic [31:0] microseconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [31:0] done_id_o,
  output logic        last_o
);
  trq_pkg::mem_req_t mem_req;
  logic [31:0] rid, rtgt;

  // entry memory, read data registered from the address
  trq_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rid_o  (rid),
    .rtgt_o (rtgt)
  );

  // request sequencer
  trq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .request_id_i   (request_id_i),
    .seconds_i      (seconds_i),
    .microseconds_i (microseconds_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .done_id_o      (done_id_o),
    .last_o         (last_o),
    .mem_o          (mem_req),
    .rid_i          (rid),
    .rtgt_i         (rtgt)
  );
endmodule

### sv/trq_checker.sv
// Port checker for the timer request queue, bound to the top level
`include "timer_request_queue_macros.svh"
module trq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  result_kind_o,
  input logic [31:0] done_id_o,
  input logic        last_o
);
  `TRQ_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(done_id_o))
  `TRQ_ASSERT_IMP(a_kind_range, clk_i, rst_ni, out_valid_o, result_kind_o <= trq_pkg::KindNoExp)
  `TRQ_ASSERT_IMP(a_single_last, clk_i, rst_ni, out_valid_o && result_kind_o != trq_pkg::KindExpired, last_o)
  `TRQ_ASSERT_IMP(a_noexp_id, clk_i, rst_ni, out_valid_o && result_kind_o == trq_pkg::KindNoExp, done_id_o == '0)
  `TRQ_ASSERT_IMP(a_ready_no_out, clk_i, rst_ni, in_ready_o, !out_valid_o)
endmodule

bind timer_request_queue trq_checker u_trq_checker (.*);

### verif/tb_timer_request_queue.sv
// Testbench for the timer request queue: random handshakes, inline predictor, scoreboard
`timescale 1ns / 100ps

module tb_timer_request_queue;

  localparam logic [1:0] ReqNone = 2'd3;  // unused selector, ignored by the block

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  req_type_i;
  logic [31:0] request_id_i;
  logic [31:0] seconds_i;
  logic [31:0] microseconds_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  result_kind_o;
  logic [31:0] done_id_o;
  logic        last_o;

  timer_request_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .request_id_i  (request_id_i),
    .seconds_i     (seconds_i),
    .microseconds_i(microseconds_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .done_id_o     (done_id_o),
    .last_o        (last_o)
  );

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] id;
    logic [31:0] sec;
    logic [31:0] usec;
  } timer_req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] id;
    logic        last;
  } timer_res_t;

  // pending stimulus and expected results
  timer_req_t req_q[$];
  timer_res_t res_exp_q[$];

  // shadow of the timer list
  logic [31:0] shadow_tick;
  logic [31:0] shadow_id[$];
  logic [31:0] shadow_tgt[$];

  int  errors = 0;
  bit  hold_off = 0;  // long receiver stall requested by stimulus

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Compute the results of one request and update the shadow list.
  task automatic predict_request(input timer_req_t r);
    int n;
    int hit;
    logic [31:0] ticks;
    logic [31:0] diff;
    logic [31:0] kid[$];
    logic [31:0] ktg[$];
    timer_res_t res[$];
    n = 0;
    if (r.kind == trq_pkg::ReqAdd) begin
      if (r.id == 0) res.push_back('{trq_pkg::KindNullId, 32'd0, 1'b0});
      else if (shadow_id.size() >= trq_pkg::Slots)
        res.push_back('{trq_pkg::KindFull, r.id, 1'b0});
      else begin
        ticks = r.sec * 32'd100 + r.usec / 32'd10000;
        if (ticks == 0) ticks = 1;
        shadow_id.push_back(r.id);
        shadow_tgt.push_back(shadow_tick + ticks);
        res.push_back('{trq_pkg::KindQueued, r.id, 1'b0});
      end
    end else if (r.kind == trq_pkg::ReqAbort) begin
      if (r.id == 0) res.push_back('{trq_pkg::KindNullId, 32'd0, 1'b0});
      else begin
        hit = -1;
        foreach (shadow_id[i]) if (hit < 0 && shadow_id[i] == r.id) hit = i;
        if (hit >= 0) begin
          shadow_id.delete(hit);
          shadow_tgt.delete(hit);
          res.push_back('{trq_pkg::KindAborted, r.id, 1'b0});
        end else res.push_back('{trq_pkg::KindNotFnd, r.id, 1'b0});
      end
    end else if (r.kind == trq_pkg::ReqTick) begin
      shadow_tick = shadow_tick + 1;
      foreach (shadow_id[i]) begin
        diff = shadow_tick - shadow_tgt[i];
        if (!diff[31] && n < trq_pkg::MaxResults) begin
          res.push_back('{trq_pkg::KindExpired, shadow_id[i], 1'b0});
          n++;
        end else begin
          kid.push_back(shadow_id[i]);
          ktg.push_back(shadow_tgt[i]);
        end
      end
      shadow_id = kid;
      shadow_tgt = ktg;
      if (res.size() == 0) res.push_back('{trq_pkg::KindNoExp, 32'd0, 1'b0});
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) res_exp_q.push_back(res[i]);
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // Acceptance seen at the rising edge; the driver reads it next falling edge.
  logic in_ready_q;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ready_q <= 1'b0;
    end else begin
      in_ready_q <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o)
        predict_request('{req_type_i, request_id_i, seconds_i, microseconds_i});
    end
  end

  // Driver: offers queued requests, changing inputs on the falling edge.
  int in_gap = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_ready_q) begin
      // hold the offer
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_valid_i <= 1'b0;
    end else if (req_q.size() > 0) begin
      in_valid_i     <= 1'b1;
      req_type_i     <= req_q[0].kind;
      request_id_i   <= req_q[0].id;
      seconds_i      <= req_q[0].sec;
      microseconds_i <= req_q[0].usec;
      void'(req_q.pop_front());
      in_gap <= gap_len();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver stall pattern, with a long hold-off when requested.
  int out_gap = 0;
  int hold_cnt = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_off && hold_cnt < 600) begin
      hold_cnt <= hold_cnt + 1;
      out_ready_i <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_gap <= gap_len();
    end
  end

  // Monitor: compares each result transfer with the oldest expectation.
  timer_res_t want;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (res_exp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d id=%h last=%b",
                 $time, result_kind_o, done_id_o, last_o);
      end else begin
        want = res_exp_q.pop_front();
        if (result_kind_o !== want.kind) begin
          errors++;
          $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, result_kind_o);
        end
        if (done_id_o !== want.id) begin
          errors++;
          $display("%0t: done_id expected %h actual %h", $time, want.id, done_id_o);
        end
        if (last_o !== want.last) begin
          errors++;
          $display("%0t: last expected %b actual %b", $time, want.last, last_o);
        end
      end
    end
  end

  function automatic logic [31:0] rand_id();
    return $urandom_range(1, 60);
  endfunction

  task automatic push_req(input logic [1:0] k, input logic [31:0] id,
                          input logic [31:0] s, input logic [31:0] u);
    req_q.push_back('{k, id, s, u});
  endtask

  int wait_cnt;
  int pick;
  logic [31:0] id_v;
  initial begin
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    req_type_i = '0;
    request_id_i = '0;
    seconds_i = '0;
    microseconds_i = '0;
    shadow_tick = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: null ids, zero delay rounding up, extreme fields, misses, ignored selector.
    push_req(trq_pkg::ReqAdd, 32'd0, 32'd5, 32'd0);
    push_req(trq_pkg::ReqAbort, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(trq_pkg::ReqAdd, 32'hFFFF_FFFF, 32'd0, 32'd9999);
    push_req(trq_pkg::ReqAdd, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(trq_pkg::ReqAdd, 32'h8000_0000, 32'h2AAA_AAAA, 32'h5555_5555);
    push_req(trq_pkg::ReqAdd, 32'h7, 32'd0, 32'd20000);
    push_req(trq_pkg::ReqAbort, 32'h1234_5678, 32'd0, 32'd0);
    push_req(ReqNone, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(trq_pkg::ReqTick, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(trq_pkg::ReqAbort, 32'h8000_0000, 32'd0, 32'd0);
    push_req(trq_pkg::ReqTick, 32'd0, 32'd0, 32'd0);
    push_req(trq_pkg::ReqTick, 32'd0, 32'd0, 32'd0);
    push_req(trq_pkg::ReqAbort, 32'h1, 32'd0, 32'd0);
    // Fill the list past full with one-tick delays, then one tick expires all 32.
    for (int i = 0; i < 33; i++) push_req(trq_pkg::ReqAdd, 32'd100 + i, 32'd0, 32'd0);
    push_req(trq_pkg::ReqTick, 32'd0, 32'd0, 32'd0);

    // Long receiver stall while the sender keeps offering requests.
    hold_off = 1;
    for (int i = 0; i < 20; i++)
      push_req(trq_pkg::ReqAdd, rand_id(), 32'd0, $urandom_range(0, 50000));
    push_req(trq_pkg::ReqTick, 32'd0, 32'd0, 32'd0);

    // Random: mostly short delays so expiries happen, some wide-range fields.
    for (int i = 0; i < 250; i++) begin
      pick = $urandom_range(0, 99);
      id_v = ($urandom_range(0, 29) == 0) ? 32'd0 : rand_id();
      if (pick < 40) begin
        if ($urandom_range(0, 7) == 0)
          push_req(trq_pkg::ReqAdd, ($urandom_range(0, 1) ? {$urandom} : id_v),
                   $urandom, $urandom);
        else
          push_req(trq_pkg::ReqAdd, id_v, $urandom_range(0, 1), $urandom_range(0, 90000));
      end else if (pick < 60) begin
        push_req(trq_pkg::ReqAbort, id_v, $urandom, $urandom);
      end else if (pick < 97) begin
        push_req(trq_pkg::ReqTick, $urandom, $urandom, $urandom);
      end else begin
        push_req(ReqNone, $urandom, $urandom, $urandom);
      end
    end
    // Finish with ten ticks; entries with longer delays stay in the list.
    for (int i = 0; i < 10; i++) push_req(trq_pkg::ReqTick, 32'd0, 32'd0, 32'd0);

    while (req_q.size() > 0 || in_valid_i) @(posedge clk_i);
    wait_cnt = 0;
    while (res_exp_q.size() > 0 && wait_cnt < 200_000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (200) @(posedge clk_i);
    if (errors == 0 && res_exp_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

### timer_request_queue.f
+incdir+sv
sv/trq_pkg.sv
sv/trq_ram.sv
sv/trq_ctrl.sv
sv/timer_request_queue.sv
sv/trq_checker.sv
verif/tb_timer_request_queue.sv
